/* rtl/dead_reckoning_pose_tracker_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the pose tracker
// Concurrent checks that are compiled for simulation and left empty for
// synthesis.
// ----------------------------------------------------------------------------
`ifndef DEAD_RECKONING_POSE_TRACKER_DEFINES_SVH
`define DEAD_RECKONING_POSE_TRACKER_DEFINES_SVH

`ifndef SYNTHESIS
// The expression holds at every clock edge outside reset.
`define DRPT_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("pose tracker assertion failed");
// The consequent holds in the cycle after the antecedent.
`define DRPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pose tracker assertion failed");
`else
`define DRPT_ASSERT(lbl, clk, rst_n, expr)
`define DRPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/drpt_pkg.sv */
// ----------------------------------------------------------------------------
// Pose tracker package
// Shared widths, fixed-point constants, command codes, the decoded command
// record and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package drpt_pkg;

    // Field and datapath widths.
    localparam int AMT_W   = 24;
    localparam int DIST_W  = 25;
    localparam int POS_W   = 32;
    localparam int HEAD_W  = 17;
    localparam int TRIG_W  = 32;
    localparam int ANG_W   = 25;
    localparam int WRAP_W  = 25;
    localparam int PROD_W  = 57;
    localparam int STEP_W  = 26;
    localparam int ARC_W   = 42;

    // Command codes on the input channel.
    localparam logic [2:0] CMD_ROTATE = 3'd0;
    localparam logic [2:0] CMD_MOVE   = 3'd1;
    localparam logic [2:0] CMD_SWING  = 3'd2;
    localparam logic [2:0] CMD_SET    = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    // Angles are 1/256 degree: 360 and 90 degrees.
    localparam logic [HEAD_W-1:0] FULL_TURN    = 17'd92160;
    localparam logic [HEAD_W-1:0] QUARTER_TURN = 17'd23040;
    localparam logic [HEAD_W-1:0] HALF_TURN    = 17'd46080;
    localparam logic [HEAD_W-1:0] THREE_QUARTER_TURN = 17'd69120;

    // Added ahead of the heading wrap so that the sum is never negative
    // (128 full turns, more than any angle step).
    localparam logic [WRAP_W-1:0] WRAP_OFFSET = 25'd11796480;
    localparam int WRAP_STEPS = 8;

    // Trig values are Q30; the start vector carries the CORDIC gain.
    localparam logic signed [TRIG_W-1:0] TRIG_ONE   = 32'sd1073741824;
    localparam logic signed [TRIG_W-1:0] TRIG_NEG   = -32'sd1073741824;
    localparam logic signed [TRIG_W-1:0] GAIN_START = 32'sd652032874;
    localparam logic signed [PROD_W-1:0] STEP_ROUND = 57'sd536870912;

    // Arc length per 1/256 degree in Q16: sqrt(648) * pi / 180 inch/degree.
    localparam logic signed [16:0]      ARC_Q16   = 17'sd29117;
    localparam logic signed [ARC_W-1:0] ARC_ROUND = 42'sd32768;

    // Decoded operation for the execution side.
    typedef enum logic [2:0] {
        OP_TURN,
        OP_MOVE,
        OP_SWING,
        OP_SET,
        OP_CLEAR,
        OP_NONE
    } op_t;

    // One decoded command as it travels through the queue.
    typedef struct packed {
        op_t                        op;
        logic signed [DIST_W-1:0]   delta;
        logic signed [DIST_W-1:0]   travel;
        logic signed [POS_W-1:0]    new_x;
        logic signed [POS_W-1:0]    new_z;
        logic [HEAD_W-1:0]          new_heading;
    } drpt_entry_t;

    // Execution sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRAP,
        ST_SETUP,
        ST_CORDIC,
        ST_MUL,
        ST_STEP,
        ST_ACC,
        ST_APPLY,
        ST_DONE
    } back_state_t;

    // Arctangent of 2^-i in Q16 degrees, rounded to nearest.
    function automatic logic signed [ANG_W-1:0] atan_q16(input logic [4:0] idx);
        logic signed [ANG_W-1:0] val;
        case (idx)
            5'd0:    val = 25'sd2949120;
            5'd1:    val = 25'sd1740967;
            5'd2:    val = 25'sd919879;
            5'd3:    val = 25'sd466945;
            5'd4:    val = 25'sd234379;
            5'd5:    val = 25'sd117304;
            5'd6:    val = 25'sd58666;
            5'd7:    val = 25'sd29335;
            5'd8:    val = 25'sd14668;
            5'd9:    val = 25'sd7334;
            5'd10:   val = 25'sd3667;
            5'd11:   val = 25'sd1833;
            5'd12:   val = 25'sd917;
            5'd13:   val = 25'sd458;
            5'd14:   val = 25'sd229;
            5'd15:   val = 25'sd115;
            5'd16:   val = 25'sd57;
            5'd17:   val = 25'sd29;
            5'd18:   val = 25'sd14;
            5'd19:   val = 25'sd7;
            5'd20:   val = 25'sd4;
            5'd21:   val = 25'sd2;
            5'd22:   val = 25'sd1;
            default: val = 25'sd0;
        endcase
        return val;
    endfunction

endpackage

/* rtl/dead_reckoning_pose_tracker.sv */
// The sequencer executes one command at a time: rotate runs the heading wrap
// loop, move runs the CORDIC and the position step, swing runs both, set and
// clear load the pose directly and unused codes return it unchanged. The front
// end and queue keep accepting commands while it is busy, until they are full;
// the CORDIC and the wrap loop each take one step per cycle.
// Reset (aresetn low, synchronous) clears the pose to zero and empties the queue.
// ----------------------------------------------------------------------------
// Dead-reckoning pose tracker
// Front end decodes motion commands into a short queue; the execution
// sequencer updates the planar pose and returns it once per command.
// ----------------------------------------------------------------------------
module dead_reckoning_pose_tracker import drpt_pkg::*; #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [2:0]               s_cmd,
    input  logic signed [AMT_W-1:0]  s_amount,
    input  logic signed [1:0]        s_drive_sign,
    input  logic signed [1:0]        s_swing_sign,
    input  logic signed [POS_W-1:0]  s_new_x,
    input  logic signed [POS_W-1:0]  s_new_z,
    input  logic [HEAD_W-1:0]        s_new_heading,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [POS_W-1:0]  m_pos_x,
    output logic signed [POS_W-1:0]  m_pos_z,
    output logic [HEAD_W-1:0]        m_heading
);

    logic         fq_valid;
    logic         fq_ready;
    drpt_entry_t  fq_data;
    logic         qb_valid;
    logic         qb_pop;
    drpt_entry_t  qb_data;

    // Command decode.
    drpt_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_amount      (s_amount),
        .s_drive_sign  (s_drive_sign),
        .s_swing_sign  (s_swing_sign),
        .s_new_x       (s_new_x),
        .s_new_z       (s_new_z),
        .s_new_heading (s_new_heading),
        .q_valid       (fq_valid),
        .q_ready       (fq_ready),
        .q_data        (fq_data)
    );

    // Decoupling queue.
    drpt_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_data  (fq_data),
        .rd_valid (qb_valid),
        .rd_pop   (qb_pop),
        .rd_data  (qb_data)
    );

    // Pose update and result transfer.
    drpt_back #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (qb_valid),
        .q_pop     (qb_pop),
        .q_data    (qb_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_pos_x   (m_pos_x),
        .m_pos_z   (m_pos_z),
        .m_heading (m_heading)
    );

endmodule

/* rtl/drpt_front.sv */
// ----------------------------------------------------------------------------
// Pose tracker command front end
// Accepts input transfers, applies the sign fields, works out the swing arc
// length and registers one decoded command for the queue.
// ----------------------------------------------------------------------------
module drpt_front import drpt_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [2:0]               s_cmd,
    input  logic signed [AMT_W-1:0]  s_amount,
    input  logic signed [1:0]        s_drive_sign,
    input  logic signed [1:0]        s_swing_sign,
    input  logic signed [POS_W-1:0]  s_new_x,
    input  logic signed [POS_W-1:0]  s_new_z,
    input  logic [HEAD_W-1:0]        s_new_heading,
    output logic                     q_valid,
    input  logic                     q_ready,
    output drpt_entry_t              q_data
);

    logic                      hold_valid_reg;
    drpt_entry_t               hold_reg;
    drpt_entry_t               entry_next;
    logic signed [DIST_W-1:0]  amt_ext;
    logic signed [DIST_W-1:0]  drive_amt;
    logic signed [DIST_W-1:0]  swing_amt;
    logic                      swing_neg;
    logic signed [ARC_W-1:0]   arc_prod;
    logic signed [ARC_W-1:0]   arc_sum;
    logic                      accept;

    // The holding register frees up whenever the queue takes its transfer.
    assign s_ready = !hold_valid_reg || q_ready;
    assign accept  = s_valid && s_ready;
    assign q_valid = hold_valid_reg;
    assign q_data  = hold_reg;

    // Signed amount after the sign fields; a sign of -2 acts as -1.
    assign amt_ext   = {s_amount[AMT_W-1], s_amount};
    assign swing_neg = s_drive_sign[1] ^ s_swing_sign[1];

    always_comb begin
        if (s_drive_sign == 2'sd0) begin
            drive_amt = '0;
        end else if (s_drive_sign[1]) begin
            drive_amt = -amt_ext;
        end else begin
            drive_amt = amt_ext;
        end
        if ((s_drive_sign == 2'sd0) || (s_swing_sign == 2'sd0)) begin
            swing_amt = '0;
        end else if (swing_neg) begin
            swing_amt = -amt_ext;
        end else begin
            swing_amt = amt_ext;
        end
    end

    // Arc length of a swing, rounded half up.
    assign arc_prod = swing_amt * ARC_Q16;
    assign arc_sum  = arc_prod + ARC_ROUND;

    // Decode the command into the queue record.
    always_comb begin
        entry_next.delta       = drive_amt;
        entry_next.travel      = drive_amt;
        entry_next.new_x       = s_new_x;
        entry_next.new_z       = s_new_z;
        entry_next.new_heading = (s_new_heading >= FULL_TURN) ?
                                 s_new_heading - FULL_TURN : s_new_heading;
        case (s_cmd)
            CMD_ROTATE: entry_next.op = OP_TURN;
            CMD_MOVE:   entry_next.op = OP_MOVE;
            CMD_SWING: begin
                entry_next.op     = OP_SWING;
                entry_next.delta  = swing_amt;
                entry_next.travel = arc_sum[DIST_W+15:16];
            end
            CMD_SET:    entry_next.op = OP_SET;
            CMD_CLEAR:  entry_next.op = OP_CLEAR;
            default:    entry_next.op = OP_NONE;
        endcase
    end

    // Holding register for one decoded command.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else if (accept) begin
            hold_valid_reg <= 1'b1;
        end else if (q_ready) begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            hold_reg <= entry_next;
        end
    end

endmodule

/* rtl/drpt_queue.sv */
// ----------------------------------------------------------------------------
// Pose tracker command queue
// Two-entry queue between the front end and the execution sequencer so
// that each side can stall on its own.
// ----------------------------------------------------------------------------
module drpt_queue import drpt_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         wr_valid,
    output logic         wr_ready,
    input  drpt_entry_t  wr_data,
    output logic         rd_valid,
    input  logic         rd_pop,
    output drpt_entry_t  rd_data
);

    drpt_entry_t  slot_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;
    logic         push;
    logic         pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* rtl/drpt_back.sv */
// ----------------------------------------------------------------------------
// Pose tracker execution sequencer
// Holds the pose, wraps the heading, runs the iterative CORDIC, applies the
// position step with saturation and drives the result register.
// ----------------------------------------------------------------------------
`include "dead_reckoning_pose_tracker_defines.svh"

module drpt_back import drpt_pkg::*; #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     q_valid,
    output logic                     q_pop,
    input  drpt_entry_t              q_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [POS_W-1:0]  m_pos_x,
    output logic signed [POS_W-1:0]  m_pos_z,
    output logic [HEAD_W-1:0]        m_heading
);

    localparam int STG_W = $clog2(CORDIC_STAGES);
    localparam logic [STG_W-1:0] LAST_STAGE = STG_W'(CORDIC_STAGES - 1);

    back_state_t               state_reg, state_next;
    drpt_entry_t               cmd_reg;

    logic signed [POS_W-1:0]   x_reg, z_reg;
    logic [HEAD_W-1:0]         heading_reg;

    logic [WRAP_W-1:0]         v_reg, v_next;
    logic [2:0]                k_reg;
    logic [WRAP_W-1:0]         wrap_limit;
    logic [WRAP_W:0]           wrap_bound;
    logic [WRAP_W:0]           v_wide;
    logic signed [WRAP_W:0]    wrap_sum;

    logic signed [TRIG_W-1:0]  cx_reg, cy_reg;
    logic signed [ANG_W-1:0]   ang_reg;
    logic [STG_W-1:0]          cnt_reg;
    logic [1:0]                quad_reg;
    logic [1:0]                quad_next;
    logic [14:0]               rem_next;
    logic signed [TRIG_W-1:0]  dx, dy;
    logic signed [ANG_W-1:0]   atan_val;
    logic signed [TRIG_W-1:0]  c_clamp, s_clamp, sn, cs;

    logic signed [PROD_W-1:0]  prod_x_reg, prod_z_reg;
    logic signed [PROD_W-1:0]  round_x, round_z;
    logic signed [STEP_W-1:0]  step_x_reg, step_z_reg;
    logic signed [POS_W:0]     sum_x, sum_z;
    logic signed [POS_W-1:0]   sat_x, sat_z;

    logic                      m_valid_reg;
    logic signed [POS_W-1:0]   out_x_reg, out_z_reg;
    logic [HEAD_W-1:0]         out_h_reg;
    logic                      out_free;

    logic wrap_en, wrap_last, setup_en, cordic_en, mul_en, step_en, acc_en;
    logic apply_en, out_load;

    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_pos_x   = out_x_reg;
    assign m_pos_z   = out_z_reg;
    assign m_heading = out_h_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    case (q_data.op)
                        OP_TURN, OP_SWING: state_next = ST_WRAP;
                        OP_MOVE:           state_next = ST_SETUP;
                        OP_SET, OP_CLEAR:  state_next = ST_APPLY;
                        default:           state_next = ST_DONE;
                    endcase
                end
            end
            ST_WRAP: begin
                if (k_reg == 3'd0) begin
                    state_next = (cmd_reg.op == OP_SWING) ? ST_SETUP : ST_DONE;
                end
            end
            ST_SETUP:  state_next = ST_CORDIC;
            ST_CORDIC: begin
                if (cnt_reg == LAST_STAGE) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:    state_next = ST_STEP;
            ST_STEP:   state_next = ST_ACC;
            ST_ACC:    state_next = ST_DONE;
            ST_APPLY:  state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath strobes for each state.
    always_comb begin
        q_pop     = 1'b0;
        wrap_en   = 1'b0;
        wrap_last = 1'b0;
        setup_en  = 1'b0;
        cordic_en = 1'b0;
        mul_en    = 1'b0;
        step_en   = 1'b0;
        acc_en    = 1'b0;
        apply_en  = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE:   q_pop     = q_valid;
            ST_WRAP: begin
                wrap_en   = 1'b1;
                wrap_last = (k_reg == 3'd0);
            end
            ST_SETUP:  setup_en  = 1'b1;
            ST_CORDIC: cordic_en = 1'b1;
            ST_MUL:    mul_en    = 1'b1;
            ST_STEP:   step_en   = 1'b1;
            ST_ACC:    acc_en    = 1'b1;
            ST_APPLY:  apply_en  = 1'b1;
            ST_DONE:   out_load  = out_free;
            default:   q_pop     = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Heading wrap: offset sum, then restoring reduction by 2^k full turns.
    assign wrap_sum   = $signed({9'b0, heading_reg}) + q_data.delta
                        + $signed({1'b0, WRAP_OFFSET});
    assign wrap_limit = WRAP_W'(FULL_TURN) << k_reg;
    assign wrap_bound = {1'b0, wrap_limit} << 1;
    assign v_wide     = {1'b0, v_reg};
    assign v_next     = (v_reg >= wrap_limit) ? v_reg - wrap_limit : v_reg;

    // Quadrant split of the heading.
    always_comb begin
        if (heading_reg < QUARTER_TURN) begin
            quad_next = 2'd0;
            rem_next  = 15'(heading_reg);
        end else if (heading_reg < HALF_TURN) begin
            quad_next = 2'd1;
            rem_next  = 15'(heading_reg - QUARTER_TURN);
        end else if (heading_reg < THREE_QUARTER_TURN) begin
            quad_next = 2'd2;
            rem_next  = 15'(heading_reg - HALF_TURN);
        end else begin
            quad_next = 2'd3;
            rem_next  = 15'(heading_reg - THREE_QUARTER_TURN);
        end
    end

    // One CORDIC rotation per cycle with floor shifts.
    assign dx       = cy_reg >>> cnt_reg;
    assign dy       = cx_reg >>> cnt_reg;
    assign atan_val = atan_q16(5'(cnt_reg));

    // Clamp to unit magnitude and map to the quadrant.
    always_comb begin
        if (cx_reg > TRIG_ONE) begin
            c_clamp = TRIG_ONE;
        end else if (cx_reg < TRIG_NEG) begin
            c_clamp = TRIG_NEG;
        end else begin
            c_clamp = cx_reg;
        end
        if (cy_reg > TRIG_ONE) begin
            s_clamp = TRIG_ONE;
        end else if (cy_reg < TRIG_NEG) begin
            s_clamp = TRIG_NEG;
        end else begin
            s_clamp = cy_reg;
        end
        case (quad_reg)
            2'd0: begin
                sn = s_clamp;
                cs = c_clamp;
            end
            2'd1: begin
                sn = c_clamp;
                cs = -s_clamp;
            end
            2'd2: begin
                sn = -s_clamp;
                cs = -c_clamp;
            end
            default: begin
                sn = -c_clamp;
                cs = s_clamp;
            end
        endcase
    end

    // Rounded step and saturating position update.
    assign round_x = prod_x_reg + STEP_ROUND;
    assign round_z = prod_z_reg + STEP_ROUND;
    assign sum_x   = {x_reg[POS_W-1], x_reg} + (POS_W+1)'(step_x_reg);
    assign sum_z   = {z_reg[POS_W-1], z_reg} + (POS_W+1)'(step_z_reg);

    always_comb begin
        if (sum_x[POS_W] != sum_x[POS_W-1]) begin
            sat_x = sum_x[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            sat_x = sum_x[POS_W-1:0];
        end
        if (sum_z[POS_W] != sum_z[POS_W-1]) begin
            sat_z = sum_z[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            sat_z = sum_z[POS_W-1:0];
        end
    end

    // Pose registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg       <= '0;
            z_reg       <= '0;
            heading_reg <= '0;
        end else begin
            if (wrap_last) begin
                heading_reg <= v_next[HEAD_W-1:0];
            end
            if (acc_en) begin
                x_reg <= sat_x;
                z_reg <= sat_z;
            end
            if (apply_en) begin
                if (cmd_reg.op == OP_SET) begin
                    x_reg       <= cmd_reg.new_x;
                    z_reg       <= cmd_reg.new_z;
                    heading_reg <= cmd_reg.new_heading;
                end else begin
                    x_reg       <= '0;
                    z_reg       <= '0;
                    heading_reg <= '0;
                end
            end
        end
    end

    // Working registers of the sequencer.
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            cmd_reg <= q_data;
            v_reg   <= wrap_sum[WRAP_W-1:0];
            k_reg   <= 3'(WRAP_STEPS - 1);
        end
        if (wrap_en) begin
            v_reg <= v_next;
            k_reg <= k_reg - 3'd1;
        end
        if (setup_en) begin
            cx_reg   <= GAIN_START;
            cy_reg   <= '0;
            ang_reg  <= $signed({2'b0, rem_next, 8'b0});
            quad_reg <= quad_next;
            cnt_reg  <= '0;
        end
        if (cordic_en) begin
            if (!ang_reg[ANG_W-1]) begin
                cx_reg  <= cx_reg - dx;
                cy_reg  <= cy_reg + dy;
                ang_reg <= ang_reg - atan_val;
            end else begin
                cx_reg  <= cx_reg + dx;
                cy_reg  <= cy_reg - dy;
                ang_reg <= ang_reg + atan_val;
            end
            cnt_reg <= cnt_reg + STG_W'(1);
        end
        if (mul_en) begin
            prod_x_reg <= cmd_reg.travel * sn;
            prod_z_reg <= cmd_reg.travel * cs;
        end
        if (step_en) begin
            step_x_reg <= round_x[STEP_W+29:30];
            step_z_reg <= round_z[STEP_W+29:30];
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_x_reg <= x_reg;
            out_z_reg <= z_reg;
            out_h_reg <= heading_reg;
        end
    end

    // Checks on the sequencer.
    `DRPT_ASSERT(a_heading_range, aclk, aresetn, heading_reg < FULL_TURN)
    `DRPT_ASSERT(a_wrap_bound, aclk, aresetn, (state_reg != ST_WRAP) || (v_wide < wrap_bound))
    `DRPT_ASSERT_NEXT(a_pop_leaves_idle, aclk, aresetn, q_pop, state_reg != ST_IDLE)
    `DRPT_ASSERT_NEXT(a_done_delivers, aclk, aresetn, (state_reg == ST_DONE) && out_free, m_valid_reg)

endmodule

/* tb/sv/dead_reckoning_pose_tracker_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Pose tracker testbench
// Drives motion commands into the pose tracker over a valid/ready channel.
// It keeps its own fixed-point copy of the pose, including the CORDIC sine
// and cosine, and compares every returned pose with the predicted one.
// Both channels idle at random, apart from one stretch with no idling.
// ----------------------------------------------------------------------------
module dead_reckoning_pose_tracker_test;
    import drpt_pkg::*;

    localparam int CORDIC_DEPTH = 16;

    // Command codes with no function; the block reports the pose unchanged.
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;

    // Two-bit sign encodings; minus two counts as minus one.
    localparam logic signed [1:0] SIGN_POS  = 2'sb01;
    localparam logic signed [1:0] SIGN_NEG  = 2'sb11;
    localparam logic signed [1:0] SIGN_NEG2 = 2'sb10;
    localparam logic signed [1:0] SIGN_ZERO = 2'sb00;

    // Fixed-point constants of the predictor.
    localparam longint TURN_UNITS    = 92160;
    localparam longint QUARTER_UNITS = 23040;
    localparam longint Q30_ONE       = 64'sd1073741824;
    localparam longint Q30_HALF      = 64'sd536870912;
    localparam longint CORDIC_START  = 64'sd652032874;
    localparam longint ARC_PER_UNIT  = 29117;
    localparam longint POS_MAX       = 64'sd2147483647;
    localparam longint POS_MIN       = -64'sd2147483648;
    localparam int     TAIL_CYCLES   = 48;

    // One motion command as it goes over the input channel.
    typedef struct {
        logic [2:0]                 cmd;
        logic signed [AMT_W-1:0]    amount;
        logic signed [1:0]          drive_sign;
        logic signed [1:0]          swing_sign;
        logic signed [POS_W-1:0]    new_x;
        logic signed [POS_W-1:0]    new_z;
        logic [HEAD_W-1:0]          new_heading;
    } motion_cmd_t;

    // One reported pose.
    typedef struct {
        logic signed [POS_W-1:0]    x;
        logic signed [POS_W-1:0]    z;
        logic [HEAD_W-1:0]          heading;
    } pose_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [2:0]              s_cmd = '0;
    logic signed [AMT_W-1:0] s_amount = '0;
    logic signed [1:0]       s_drive_sign = '0;
    logic signed [1:0]       s_swing_sign = '0;
    logic signed [POS_W-1:0] s_new_x = '0;
    logic signed [POS_W-1:0] s_new_z = '0;
    logic [HEAD_W-1:0]       s_new_heading = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic signed [POS_W-1:0] m_pos_x;
    logic signed [POS_W-1:0] m_pos_z;
    logic [HEAD_W-1:0]       m_heading;

    // Pose as tracked by the predictor.
    longint tracked_x;
    longint tracked_z;
    longint tracked_heading;

    pose_t  expected_poses[$];
    bit     no_idle = 1'b0;
    int     cmd_count [8];
    int     poses_checked = 0;
    int     mismatches = 0;

    dead_reckoning_pose_tracker #(
        .CORDIC_STAGES(CORDIC_DEPTH)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_amount      (s_amount),
        .s_drive_sign  (s_drive_sign),
        .s_swing_sign  (s_swing_sign),
        .s_new_x       (s_new_x),
        .s_new_z       (s_new_z),
        .s_new_heading (s_new_heading),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pos_x       (m_pos_x),
        .m_pos_z       (m_pos_z),
        .m_heading     (m_heading)
    );

    // 100 MHz clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Arctangent of 2^-i in Q16 degrees.
    function automatic longint atan_step(input int i);
        case (i)
            0:       return 2949120;
            1:       return 1740967;
            2:       return 919879;
            3:       return 466945;
            4:       return 234379;
            5:       return 117304;
            6:       return 58666;
            7:       return 29335;
            8:       return 14668;
            9:       return 7334;
            10:      return 3667;
            11:      return 1833;
            12:      return 917;
            13:      return 458;
            14:      return 229;
            15:      return 115;
            16:      return 57;
            17:      return 29;
            18:      return 14;
            19:      return 7;
            20:      return 4;
            21:      return 2;
            22:      return 1;
            default: return 0;
        endcase
    endfunction

    function automatic longint saturate32(input longint v);
        if (v > POS_MAX) return POS_MAX;
        if (v < POS_MIN) return POS_MIN;
        return v;
    endfunction

    function automatic longint sign_unit(input logic signed [1:0] v);
        return (v > 0) ? 64'sd1 : ((v < 0) ? -64'sd1 : 64'sd0);
    endfunction

    // Q30 sine and cosine of a heading: CORDIC over the angle within its
    // quadrant, then the quadrant decides the signs and the swap.
    function automatic void heading_trig(input longint h, output longint sn,
                                         output longint cs);
        longint cx;
        longint cy;
        longint ang;
        longint dx;
        longint dy;
        longint s;
        longint c;
        cx  = CORDIC_START;
        cy  = 0;
        ang = (h % QUARTER_UNITS) * 256;
        for (int i = 0; i < CORDIC_DEPTH && i < 24; i++) begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (ang >= 0) begin
                cx  = cx - dx;
                cy  = cy + dy;
                ang = ang - atan_step(i);
            end else begin
                cx  = cx + dx;
                cy  = cy - dy;
                ang = ang + atan_step(i);
            end
        end
        c = (cx > Q30_ONE) ? Q30_ONE : ((cx < -Q30_ONE) ? -Q30_ONE : cx);
        s = (cy > Q30_ONE) ? Q30_ONE : ((cy < -Q30_ONE) ? -Q30_ONE : cy);
        case ((h / QUARTER_UNITS) % 4)
            0: begin
                sn = s;
                cs = c;
            end
            1: begin
                sn = c;
                cs = -s;
            end
            2: begin
                sn = -s;
                cs = -c;
            end
            default: begin
                sn = -c;
                cs = s;
            end
        endcase
    endfunction

    // Heading sum wrapped into one full turn, negative sums included.
    function automatic void turn_heading(input longint delta);
        longint h;
        h = (tracked_heading + delta) % TURN_UNITS;
        if (h < 0) h = h + TURN_UNITS;
        tracked_heading = h;
    endfunction

    // Step along the current heading with rounded Q30 products.
    function automatic void move_forward(input longint d);
        longint sn;
        longint cs;
        heading_trig(tracked_heading, sn, cs);
        tracked_x = saturate32(tracked_x + ((d * sn + Q30_HALF) >>> 30));
        tracked_z = saturate32(tracked_z + ((d * cs + Q30_HALF) >>> 30));
    endfunction

    // Applies one command to the tracked pose and returns the pose to report.
    function automatic pose_t predict_pose(input motion_cmd_t c);
        longint amt;
        longint arc_angle;
        pose_t  p;
        amt = c.amount;
        case (c.cmd)
            CMD_ROTATE: turn_heading(amt * sign_unit(c.drive_sign));
            CMD_MOVE:   move_forward(amt * sign_unit(c.drive_sign));
            CMD_SWING: begin
                arc_angle = amt * sign_unit(c.drive_sign) * sign_unit(c.swing_sign);
                turn_heading(arc_angle);
                move_forward((arc_angle * ARC_PER_UNIT + 32768) >>> 16);
            end
            CMD_SET: begin
                tracked_x       = c.new_x;
                tracked_z       = c.new_z;
                tracked_heading = longint'(c.new_heading) % TURN_UNITS;
            end
            CMD_CLEAR: begin
                tracked_x       = 0;
                tracked_z       = 0;
                tracked_heading = 0;
            end
            default: ;
        endcase
        p.x       = tracked_x[POS_W-1:0];
        p.z       = tracked_z[POS_W-1:0];
        p.heading = tracked_heading[HEAD_W-1:0];
        return p;
    endfunction

    function automatic logic signed [POS_W-1:0] random_position();
        case ($urandom_range(0, 4))
            0, 1:    return POS_W'($urandom());
            2:       return POS_W'(POS_MAX - longint'($urandom_range(0, 200000)));
            3:       return POS_W'(POS_MIN + longint'($urandom_range(0, 200000)));
            default: return POS_W'(int'($urandom_range(0, 200000)) - 100000);
        endcase
    endfunction

    function automatic logic signed [1:0] random_sign();
        if ($urandom_range(0, 99) < 80) return $urandom_range(0, 1) ? SIGN_POS : SIGN_NEG;
        return 2'($urandom_range(0, 3));
    endfunction

    // Mostly ordinary motion with random content; set pose, clear and the
    // unused codes are mixed in more rarely.
    function automatic motion_cmd_t random_command();
        motion_cmd_t c;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)      c.cmd = CMD_ROTATE;
        else if (pick < 60) c.cmd = CMD_MOVE;
        else if (pick < 85) c.cmd = CMD_SWING;
        else if (pick < 93) c.cmd = CMD_SET;
        else if (pick < 96) c.cmd = CMD_CLEAR;
        else                c.cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        if ($urandom_range(0, 9) < 3) c.amount = AMT_W'($urandom());
        else c.amount = AMT_W'(int'($urandom_range(0, 92160)) - 46080);
        c.drive_sign = random_sign();
        c.swing_sign = random_sign();
        c.new_x      = random_position();
        c.new_z      = random_position();
        if ($urandom_range(0, 99) < 85) c.new_heading = HEAD_W'($urandom_range(0, 92159));
        else c.new_heading = HEAD_W'($urandom_range(92160, 131071));
        return c;
    endfunction

    // Sends one command, waits for its transfer and records the expected pose.
    task automatic send_command(input motion_cmd_t c);
        if (!no_idle && $urandom_range(0, 99) < 40) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_cmd         <= c.cmd;
        s_amount      <= c.amount;
        s_drive_sign  <= c.drive_sign;
        s_swing_sign  <= c.swing_sign;
        s_new_x       <= c.new_x;
        s_new_z       <= c.new_z;
        s_new_heading <= c.new_heading;
        do @(posedge aclk); while (!s_ready);
        expected_poses.push_back(predict_pose(c));
        cmd_count[c.cmd]++;
    endtask

    // Motion command; the set pose fields carry random values.
    task automatic send_motion(input logic [2:0] cmd, input logic signed [AMT_W-1:0] amount,
                               input logic signed [1:0] ds, input logic signed [1:0] ss);
        motion_cmd_t c;
        c            = random_command();
        c.cmd        = cmd;
        c.amount     = amount;
        c.drive_sign = ds;
        c.swing_sign = ss;
        send_command(c);
    endtask

    // Set pose; the motion fields carry random values.
    task automatic send_set_pose(input logic signed [POS_W-1:0] x,
                                 input logic signed [POS_W-1:0] z,
                                 input logic [HEAD_W-1:0] h);
        motion_cmd_t c;
        c             = random_command();
        c.cmd         = CMD_SET;
        c.new_x       = x;
        c.new_z       = z;
        c.new_heading = h;
        send_command(c);
    endtask

    // Extremes, every command, wrapping, odd signs and saturation.
    task automatic test_directed_cases();
        send_motion(CMD_CLEAR, 24'sd0, SIGN_POS, SIGN_POS);
        send_motion(CMD_MOVE, 24'sd25600, SIGN_POS, SIGN_ZERO);
        send_motion(CMD_ROTATE, 24'sd23040, SIGN_POS, SIGN_NEG);
        send_motion(CMD_MOVE, 24'sh800000, SIGN_POS, SIGN_POS);
        // Heading of 90 degrees turned back by 100 wraps to 350.
        send_motion(CMD_ROTATE, -24'sd25600, SIGN_POS, SIGN_POS);
        send_motion(CMD_ROTATE, 24'sh7FFFFF, SIGN_NEG2, SIGN_POS);
        send_motion(CMD_ROTATE, 24'sd5000, SIGN_ZERO, SIGN_POS);
        send_motion(CMD_MOVE, 24'sd5000, SIGN_ZERO, SIGN_POS);
        send_motion(CMD_SWING, 24'sd11520, SIGN_POS, SIGN_NEG);
        send_motion(CMD_SWING, 24'sh800000, SIGN_NEG, SIGN_NEG2);
        send_motion(CMD_SWING, 24'sd30000, SIGN_POS, SIGN_ZERO);
        // Facing 90 degrees near the top of x: the move saturates.
        send_set_pose(32'sd2147483000, -32'sd2147483000, 17'd23040);
        send_motion(CMD_MOVE, 24'sh7FFFFF, SIGN_POS, SIGN_POS);
        // Facing 180 degrees near the bottom of z: the move saturates.
        send_set_pose(-32'sd2147483000, -32'sd2147483000, 17'd46080);
        send_motion(CMD_MOVE, 24'sh7FFFFF, SIGN_POS, SIGN_POS);
        send_set_pose(32'sh80000000, 32'sh7FFFFFFF, 17'd69120);
        send_motion(CMD_MOVE, 24'sh800000, SIGN_NEG, SIGN_POS);
        // Headings of a full turn and more are reduced on set pose.
        send_set_pose(32'sd0, 32'sd0, 17'h1FFFF);
        send_set_pose(32'sd1000, -32'sd1000, 17'd92160);
        send_set_pose(32'sh7FFFFFFF, 32'sh80000000, 17'd92159);
        send_motion(CMD_MOVE, -24'sd1000, SIGN_NEG2, SIGN_POS);
        for (int k = CMD_SPARE_LO; k <= CMD_SPARE_HI; k++) begin
            send_motion(3'(k), 24'sh7FFFFF, SIGN_POS, SIGN_POS);
        end
        send_motion(CMD_CLEAR, 24'sh800000, SIGN_NEG, SIGN_NEG);
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count) send_command(random_command());
    endtask

    // Same mix with neither side idling.
    task automatic test_back_to_back(input int count);
        no_idle = 1'b1;
        repeat (count) send_command(random_command());
        no_idle = 1'b0;
    endtask

    // Result side: random backpressure and the check of each transfer.
    always @(posedge aclk) begin
        pose_t want;
        if (aresetn && m_valid && m_ready) begin
            poses_checked++;
            if (expected_poses.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: pose x=%0d z=%0d heading=%0d with none expected",
                             $realtime, m_pos_x, m_pos_z, m_heading);
                end
            end else begin
                want = expected_poses.pop_front();
                if (m_pos_x !== want.x || m_pos_z !== want.z || m_heading !== want.heading) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: pose x=%0d z=%0d heading=%0d, expected x=%0d z=%0d heading=%0d",
                                 $realtime, m_pos_x, m_pos_z, m_heading,
                                 want.x, want.z, want.heading);
                    end
                end
            end
        end
        m_ready <= no_idle || ($urandom_range(0, 99) >= 25);
    end

    // Main sequence.
    initial begin
        tracked_x       = 0;
        tracked_z       = 0;
        tracked_heading = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_cases();
        test_random_traffic(1300);
        test_back_to_back(230);
        s_valid <= 1'b0;
        while (expected_poses.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("Sent %0d rotate, %0d move, %0d swing, %0d set pose, %0d clear and %0d unused codes.",
                 cmd_count[CMD_ROTATE], cmd_count[CMD_MOVE], cmd_count[CMD_SWING],
                 cmd_count[CMD_SET], cmd_count[CMD_CLEAR],
                 cmd_count[5] + cmd_count[6] + cmd_count[7]);
        $display("Compared %0d returned poses, %0d mismatches.", poses_checked, mismatches);
        if (mismatches == 0 && expected_poses.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
